// File: rtl/core/lcdsmt_pkg.sv
// Shared types and constants for the LCD scanline mode timer.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package lcdsmt_pkg;

    // Line timing, in dots and lines
    localparam logic [9:0] LINE_DOTS   = 10'd456;
    localparam logic [9:0] OAM_DOTS    = 10'd80;
    localparam logic [9:0] XFER_DOTS   = 10'd172;
    localparam logic [9:0] OAM_START   = LINE_DOTS - OAM_DOTS;
    localparam logic [9:0] XFER_START  = LINE_DOTS - OAM_DOTS - XFER_DOTS;
    localparam logic [7:0] VBLANK_LINE = 8'd144;
    localparam logic [7:0] LAST_LINE   = 8'd153;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // Register map, word index
    typedef enum logic [2:0] {
        REG_DISPLAY_EN   = 3'd0,
        REG_LINE_COMPARE = 3'd1,
        REG_HBLANK_IE    = 3'd2,
        REG_VBLANK_IE    = 3'd3,
        REG_OAM_IE       = 3'd4,
        REG_COINC_IE     = 3'd5
    } lcdsmt_reg_t;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } lcdsmt_mode_t;

    typedef struct packed {
        logic       display_en;
        logic [7:0] line_compare;
        logic       hblank_irq_enable;
        logic       vblank_mode_irq_enable;
        logic       oam_irq_enable;
        logic       coincidence_irq_enable;
    } lcdsmt_cfg_t;

    typedef struct packed {
        lcdsmt_mode_t mode;
        logic [7:0]   line;
        logic         coincidence;
        logic         mode_irq;
        logic         compare_irq;
        logic         vblank_irq;
        logic         render_request;
    } lcdsmt_result_t;

endpackage

`default_nettype wire

// File: rtl/core/lcdsmt_regs.sv
// APB configuration registers of the LCD scanline mode timer.
// Depends on lcdsmt_pkg.
`default_nettype none

module lcdsmt_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [lcdsmt_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [lcdsmt_pkg::DATA_W-1:0]    pwdata,
    output logic      [lcdsmt_pkg::DATA_W-1:0]    prdata,
    output logic                                  pready,
    output lcdsmt_pkg::lcdsmt_cfg_t               cfg
);

    lcdsmt_pkg::lcdsmt_cfg_t cfg_reg;
    lcdsmt_pkg::lcdsmt_cfg_t cfg_next;
    lcdsmt_pkg::lcdsmt_reg_t reg_sel;
    logic                    wr_en;

    assign pready  = 1'b1;
    assign reg_sel = lcdsmt_pkg::lcdsmt_reg_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                lcdsmt_pkg::REG_DISPLAY_EN:   cfg_next.display_en             = pwdata[0];
                lcdsmt_pkg::REG_LINE_COMPARE: cfg_next.line_compare           = pwdata[7:0];
                lcdsmt_pkg::REG_HBLANK_IE:    cfg_next.hblank_irq_enable      = pwdata[0];
                lcdsmt_pkg::REG_VBLANK_IE:    cfg_next.vblank_mode_irq_enable = pwdata[0];
                lcdsmt_pkg::REG_OAM_IE:       cfg_next.oam_irq_enable         = pwdata[0];
                lcdsmt_pkg::REG_COINC_IE:     cfg_next.coincidence_irq_enable = pwdata[0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    always_comb
    begin
        prdata = '0;
        case (reg_sel)
            lcdsmt_pkg::REG_DISPLAY_EN:   prdata[0]   = cfg_reg.display_en;
            lcdsmt_pkg::REG_LINE_COMPARE: prdata[7:0] = cfg_reg.line_compare;
            lcdsmt_pkg::REG_HBLANK_IE:    prdata[0]   = cfg_reg.hblank_irq_enable;
            lcdsmt_pkg::REG_VBLANK_IE:    prdata[0]   = cfg_reg.vblank_mode_irq_enable;
            lcdsmt_pkg::REG_OAM_IE:       prdata[0]   = cfg_reg.oam_irq_enable;
            lcdsmt_pkg::REG_COINC_IE:     prdata[0]   = cfg_reg.coincidence_irq_enable;
            default:                      prdata      = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/core/lcdsmt_timer.sv
// Dot counter, scanline and mode state with the per-transaction status logic.
// Depends on lcdsmt_pkg.
`default_nettype none

module lcdsmt_timer (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      step,
    input  wire logic [7:0]                cycles,
    input  lcdsmt_pkg::lcdsmt_cfg_t        cfg,
    output lcdsmt_pkg::lcdsmt_result_t     result
);

    logic [9:0]               dot_cnt_reg;
    logic [9:0]               dot_cnt_next;
    logic [7:0]               line_reg;
    logic [7:0]               line_next;
    lcdsmt_pkg::lcdsmt_mode_t last_mode_reg;
    lcdsmt_pkg::lcdsmt_mode_t last_mode_next;

    lcdsmt_pkg::lcdsmt_mode_t mode;
    logic                     mode_ie;
    logic                     tick;
    logic [7:0]               line_inc;

    always_comb
    begin
        // status from the state before the tick
        if (line_reg >= lcdsmt_pkg::VBLANK_LINE)
        begin
            mode    = lcdsmt_pkg::MODE_VBLANK;
            mode_ie = cfg.vblank_mode_irq_enable;
        end
        else if (dot_cnt_reg >= lcdsmt_pkg::OAM_START)
        begin
            mode    = lcdsmt_pkg::MODE_OAM;
            mode_ie = cfg.oam_irq_enable;
        end
        else if (dot_cnt_reg >= lcdsmt_pkg::XFER_START)
        begin
            mode    = lcdsmt_pkg::MODE_XFER;
            mode_ie = 1'b0;
        end
        else
        begin
            mode    = lcdsmt_pkg::MODE_HBLANK;
            mode_ie = cfg.hblank_irq_enable;
        end

        tick     = {2'b00, cycles} >= dot_cnt_reg;
        line_inc = line_reg + 8'd1;

        result         = '0;
        result.mode    = lcdsmt_pkg::MODE_HBLANK;
        dot_cnt_next   = lcdsmt_pkg::LINE_DOTS;
        line_next      = '0;
        last_mode_next = lcdsmt_pkg::MODE_HBLANK;

        if (cfg.display_en)
        begin
            last_mode_next     = mode;
            result.mode        = mode;
            result.mode_irq    = mode_ie && (mode != last_mode_reg);
            result.coincidence = (line_reg == cfg.line_compare);
            result.compare_irq = result.coincidence && cfg.coincidence_irq_enable;

            if (tick)
            begin
                // remainder dropped on reload
                dot_cnt_next = lcdsmt_pkg::LINE_DOTS;
                line_next    = (line_inc > lcdsmt_pkg::LAST_LINE) ? 8'd0 : line_inc;
                result.vblank_irq     = (line_inc == lcdsmt_pkg::VBLANK_LINE);
                result.render_request = (line_next < lcdsmt_pkg::VBLANK_LINE);
            end
            else
            begin
                dot_cnt_next = dot_cnt_reg - {2'b00, cycles};
                line_next    = line_reg;
            end
        end
        result.line = line_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_cnt_reg   <= lcdsmt_pkg::LINE_DOTS;
            line_reg      <= '0;
            last_mode_reg <= lcdsmt_pkg::MODE_HBLANK;
        end
        else if (step)
        begin
            dot_cnt_reg   <= dot_cnt_next;
            line_reg      <= line_next;
            last_mode_reg <= last_mode_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/lcdsmt_out_reg.sv
// Result register with valid/ready handshake; takes a new result each cycle while the slot is free.
// Depends on lcdsmt_pkg.
`default_nettype none

module lcdsmt_out_reg (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      load,
    input  lcdsmt_pkg::lcdsmt_result_t     result,
    input  wire logic                      out_ready,
    output logic                           out_valid,
    output logic                           load_ready,
    output lcdsmt_pkg::lcdsmt_result_t     data
);

    logic                       valid_reg;
    logic                       valid_next;
    lcdsmt_pkg::lcdsmt_result_t data_reg;

    // slot is free when empty or being drained this cycle
    assign load_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign out_valid = valid_reg;
    assign data      = data_reg;

endmodule

`default_nettype wire

// File: rtl/core/lcd_scanline_mode_timer.sv
// LCD scanline mode timer, top level. Instantiates lcdsmt_regs, lcdsmt_timer
// and lcdsmt_out_reg; uses lcdsmt_pkg.
//
// Each input transaction carries the CPU time elapsed since the previous one, which is subtracted from the dot counter.
// The block reports the LCD mode (0 hblank, 1 vblank, 2 OAM, 3 transfer)
// taken from the line and dot counter as they stood before the step, the line
// after the step, line-compare coincidence, and the mode, compare, vblank and
// render requests. Throughput is one transaction per clock while the output is not
// stalled: the status and the counter update are a single short compare/subtract
// path from the state registers into the result register, so the result is presented
// in the cycle after acceptance. in_ready is high whenever the result register is
// empty or is being taken in the same cycle, so a stalled output holds back at most
// one result. Configuration is through an APB-style port, word registers at byte
// offsets 0x00 display enable, 0x04 line_compare, 0x08 hblank IE, 0x0C vblank IE,
// 0x10 OAM IE, 0x14 coincidence IE; pready is tied high. Write registers only
// while no transaction is in flight. Clearing the display enable holds the timing
// in its reset state (line 0, full 456-dot count) while interrupt enables and
// line_compare keep their values.
`default_nettype none

module lcd_scanline_mode_timer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // input transactions
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [7:0]                    cycles,

    // result transactions
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         mode,
    output logic [7:0]                         line,
    output logic                               coincidence,
    output logic                               mode_irq,
    output logic                               compare_irq,
    output logic                               vblank_irq,
    output logic                               render_request,

    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lcdsmt_pkg::ADDR_W-1:0] paddr,
    input  wire logic [lcdsmt_pkg::DATA_W-1:0] pwdata,
    output logic      [lcdsmt_pkg::DATA_W-1:0] prdata,
    output logic                               pready
);

    lcdsmt_pkg::lcdsmt_cfg_t    cfg;
    lcdsmt_pkg::lcdsmt_result_t step_result;
    lcdsmt_pkg::lcdsmt_result_t out_data;
    logic                       step;

    // a transaction is taken when the result slot can absorb its result
    assign step = in_valid && in_ready;

    lcdsmt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lcdsmt_timer u_timer (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cycles (cycles),
        .cfg    (cfg),
        .result (step_result)
    );

    lcdsmt_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .result     (step_result),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .load_ready (in_ready),
        .data       (out_data)
    );

    assign mode           = out_data.mode;
    assign line           = out_data.line;
    assign coincidence    = out_data.coincidence;
    assign mode_irq       = out_data.mode_irq;
    assign compare_irq    = out_data.compare_irq;
    assign vblank_irq     = out_data.vblank_irq;
    assign render_request = out_data.render_request;

endmodule

`default_nettype wire
